[rtl/bmp_stream_to_argb_pixels_top_assert.svh]
// Assertion macros for the BMP to ARGB decoder.
// Used by the top level; expects signals clk and rst in scope.
`ifndef BMP_STREAM_TO_ARGB_PIXELS_TOP_ASSERT_SVH
`define BMP_STREAM_TO_ARGB_PIXELS_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BMPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define BMPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bmpa_pkg.sv]
// Shared types and constants of the BMP to ARGB decoder.
// No dependencies; imported by every module of the block.
package bmpa_pkg;

  // Default size limits
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Header layout and legal values
  localparam logic [15:0] BMP_SIGNATURE     = 16'h4D42;
  localparam logic [15:0] BPP_24            = 16'd24;
  localparam logic [15:0] BPP_32            = 16'd32;
  localparam logic [7:0]  ALPHA_OPAQUE      = 8'd255;
  localparam logic [31:0] MIN_PIXEL_OFFSET  = 32'd54;
  localparam int          FILE_HEADER_BYTES = 14;

  // Position of the last byte of each header field
  localparam logic [31:0] POS_SIGNATURE   = 32'd1;
  localparam logic [31:0] POS_OFFSET      = 32'd13;
  localparam logic [31:0] POS_WIDTH       = 32'(FILE_HEADER_BYTES + 7);
  localparam logic [31:0] POS_HEIGHT      = 32'(FILE_HEADER_BYTES + 11);
  localparam logic [31:0] POS_BIT_COUNT   = 32'(FILE_HEADER_BYTES + 15);
  localparam logic [31:0] POS_COMPRESSION = 32'(FILE_HEADER_BYTES + 19);

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;

  // Result status codes
  typedef enum logic [2:0] {
    STATUS_PIXEL      = 3'd0,
    STATUS_BAD_SIG    = 3'd1,
    STATUS_BAD_BPP    = 3'd2,
    STATUS_COMPRESSED = 3'd3,
    STATUS_TOO_LARGE  = 3'd4,
    STATUS_BAD_OFFSET = 3'd5
  } status_t;

  // Command kinds passed from the parser to the pixel stage
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } bmpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] pixel_index;
    logic [31:0] pixel_color;
    logic        last_pixel;
  } bmpa_out_t;

  // One queued command: image start, assembled pixel or error
  typedef struct packed {
    cmd_kind_t   kind;
    status_t     status;
    logic [23:0] data;       // row base on init, BGR color on pixel
    logic [23:0] step;       // image width on init
    logic        bottom_up;
    logic        row_end;
    logic        last;
  } bmpa_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bmpa_qstat_t;

endpackage

[rtl/bmpa_front.sv]
// Byte parser: header capture and checks, offset skip, padding skip, pixel assembly.
// Depends on bmpa_pkg; pushes commands into bmpa_queue.
module bmpa_front import bmpa_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  bmpa_in_t    byte_data,
  input  bmpa_qstat_t qstat,
  output logic        push,
  output bmpa_cmd_t   push_cmd
);

  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = DW + HW;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  phase_t         phase, phase_next, phase_eff;
  logic [31:0]    byte_position, byte_position_next, pos_eff;
  logic [31:0]    header_shift, header_shift_next, shift_eff, shift_new;
  logic [31:0]    pixel_offset, pixel_offset_next;
  logic [DW-1:0]  image_width, image_width_next;
  logic [HW-1:0]  image_height, image_height_next;
  logic           size_bad, size_bad_next, size_bad_eff;
  logic           rows_bottom_up, rows_bottom_up_next;
  logic           four_byte_pixels, four_byte_pixels_next;
  logic [1:0]     byte_in_pixel, byte_in_pixel_next, last_byte;
  logic [23:0]    partial_color, partial_color_next, color_now;
  logic [DW-1:0]  column_count, column_count_next;
  logic [HW-1:0]  row_count, row_count_next;
  logic [1:0]     pad_remaining, pad_remaining_next;
  logic [PW-1:0]  base_product;
  logic [23:0]    base_init;
  logic [31:0]    height_mag;
  logic [15:0]    bit_count;
  logic           accept, do_pixel, row_end, last;

  assign byte_ready = !qstat.full;
  assign accept     = byte_valid && byte_ready;
  assign last_byte  = four_byte_pixels ? 2'd3 : 2'd2;

  // Precompute the base index of the bottom row for bottom-up images
  assign base_product = PW'(image_height - 1'b1) * PW'(image_width);

  always_ff @(posedge clk) begin
    base_init <= 24'(base_product);
  end

  // Parse one byte
  always_comb begin
    if (byte_data.start_of_file) begin
      phase_eff    = PH_HEADER;
      pos_eff      = '0;
      shift_eff    = '0;
      size_bad_eff = 1'b0;
    end else begin
      phase_eff    = phase;
      pos_eff      = byte_position;
      shift_eff    = header_shift;
      size_bad_eff = size_bad;
    end
    shift_new  = {byte_data.byte_value, shift_eff[31:8]};
    height_mag = shift_new[31] ? (32'd0 - shift_new) : shift_new;
    bit_count  = shift_new[31:16];

    phase_next            = phase;
    byte_position_next    = byte_position;
    header_shift_next     = header_shift;
    pixel_offset_next     = pixel_offset;
    image_width_next      = image_width;
    image_height_next     = image_height;
    size_bad_next         = size_bad;
    rows_bottom_up_next   = rows_bottom_up;
    four_byte_pixels_next = four_byte_pixels;
    byte_in_pixel_next    = byte_in_pixel;
    partial_color_next    = partial_color;
    column_count_next     = column_count;
    row_count_next        = row_count;
    pad_remaining_next    = pad_remaining;
    color_now             = partial_color;
    row_end               = 1'b0;
    last                  = 1'b0;
    do_pixel              = 1'b0;
    push                  = 1'b0;
    push_cmd              = '0;

    if (accept) begin
      phase_next         = phase_eff;
      byte_position_next = pos_eff;
      header_shift_next  = shift_eff;
      size_bad_next      = size_bad_eff;

      case (phase_eff)
        PH_HEADER: begin
          header_shift_next  = shift_new;
          byte_position_next = pos_eff + 32'd1;
          case (pos_eff)
            POS_SIGNATURE: begin
              if (shift_new[31:16] != BMP_SIGNATURE) begin
                push            = 1'b1;
                push_cmd.kind   = CMD_ERROR;
                push_cmd.status = STATUS_BAD_SIG;
                phase_next      = PH_IDLE;
              end
            end
            POS_OFFSET: begin
              pixel_offset_next = shift_new;
            end
            POS_WIDTH: begin
              image_width_next = DW'(shift_new);
              if (shift_new[31] || shift_new > 32'(MAX_WIDTH)) begin
                size_bad_next = 1'b1;
              end
            end
            POS_HEIGHT: begin
              image_height_next   = HW'(height_mag);
              rows_bottom_up_next = !shift_new[31] && (shift_new != 32'd0);
              if (height_mag > 32'(MAX_HEIGHT)) begin
                size_bad_next = 1'b1;
              end
            end
            POS_BIT_COUNT: begin
              if (bit_count != BPP_24 && bit_count != BPP_32) begin
                push            = 1'b1;
                push_cmd.kind   = CMD_ERROR;
                push_cmd.status = STATUS_BAD_BPP;
                phase_next      = PH_IDLE;
              end
              four_byte_pixels_next = (bit_count == BPP_32);
            end
            POS_COMPRESSION: begin
              if (shift_new != 32'd0) begin
                push            = 1'b1;
                push_cmd.kind   = CMD_ERROR;
                push_cmd.status = STATUS_COMPRESSED;
                phase_next      = PH_IDLE;
              end else if (pixel_offset < MIN_PIXEL_OFFSET) begin
                push            = 1'b1;
                push_cmd.kind   = CMD_ERROR;
                push_cmd.status = STATUS_BAD_OFFSET;
                phase_next      = PH_IDLE;
              end else if (size_bad_eff) begin
                push            = 1'b1;
                push_cmd.kind   = CMD_ERROR;
                push_cmd.status = STATUS_TOO_LARGE;
                phase_next      = PH_IDLE;
              end else if (image_width == '0 || image_height == '0) begin
                // empty image: nothing to draw
                phase_next = PH_IDLE;
              end else begin
                push               = 1'b1;
                push_cmd.kind      = CMD_INIT;
                push_cmd.data      = rows_bottom_up ? base_init : 24'd0;
                push_cmd.step      = 24'(image_width);
                push_cmd.bottom_up = rows_bottom_up;
                column_count_next  = '0;
                row_count_next     = '0;
                byte_in_pixel_next = '0;
                pad_remaining_next = '0;
                partial_color_next = '0;
                phase_next         = PH_SKIP;
              end
            end
            default: ;
          endcase
        end
        PH_SKIP: begin
          if (pos_eff < pixel_offset) begin
            byte_position_next = pos_eff + 32'd1;
          end else begin
            phase_next = PH_PIXELS;
            do_pixel   = 1'b1;
          end
        end
        PH_PIXELS: do_pixel = 1'b1;
        default: ;
      endcase

      // Drop padding, else collect one color byte and emit on the pixel's last byte
      if (do_pixel) begin
        if (pad_remaining != 2'd0) begin
          pad_remaining_next = pad_remaining - 2'd1;
        end else begin
          case (byte_in_pixel)
            2'd0: color_now[7:0]   = byte_data.byte_value;
            2'd1: color_now[15:8]  = byte_data.byte_value;
            2'd2: color_now[23:16] = byte_data.byte_value;
            default: ;
          endcase
          if (byte_in_pixel != last_byte) begin
            byte_in_pixel_next = byte_in_pixel + 2'd1;
            partial_color_next = color_now;
          end else begin
            row_end            = (column_count == image_width - 1'b1);
            last               = row_end && (row_count == image_height - 1'b1);
            push               = 1'b1;
            push_cmd.kind      = CMD_PIXEL;
            push_cmd.data      = color_now;
            push_cmd.row_end   = row_end;
            push_cmd.last      = last;
            byte_in_pixel_next = '0;
            partial_color_next = '0;
            if (last) begin
              phase_next = PH_IDLE;
            end else if (row_end) begin
              column_count_next  = '0;
              row_count_next     = row_count + 1'b1;
              pad_remaining_next = four_byte_pixels ? 2'd0 : 2'(image_width);
            end else begin
              column_count_next = column_count + 1'b1;
            end
          end
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      byte_position    <= '0;
      header_shift     <= '0;
      pixel_offset     <= '0;
      image_width      <= '0;
      image_height     <= '0;
      size_bad         <= 1'b0;
      rows_bottom_up   <= 1'b0;
      four_byte_pixels <= 1'b0;
      byte_in_pixel    <= '0;
      partial_color    <= '0;
      column_count     <= '0;
      row_count        <= '0;
      pad_remaining    <= '0;
    end else begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      header_shift     <= header_shift_next;
      pixel_offset     <= pixel_offset_next;
      image_width      <= image_width_next;
      image_height     <= image_height_next;
      size_bad         <= size_bad_next;
      rows_bottom_up   <= rows_bottom_up_next;
      four_byte_pixels <= four_byte_pixels_next;
      byte_in_pixel    <= byte_in_pixel_next;
      partial_color    <= partial_color_next;
      column_count     <= column_count_next;
      row_count        <= row_count_next;
      pad_remaining    <= pad_remaining_next;
    end
  end

endmodule

[rtl/bmpa_queue.sv]
// Short command queue between the byte parser and the pixel stage.
// Depends on bmpa_pkg for the command type and depth.
module bmpa_queue import bmpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  bmpa_cmd_t   push_cmd,
  input  logic        pop,
  output bmpa_cmd_t   head,
  output bmpa_qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

  bmpa_cmd_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == FULL_COUNT);
  assign qstat.empty = (count == '0);

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/bmpa_back.sv]
// Pixel stage: tracks the destination index and drives the result register.
// Depends on bmpa_pkg; pops commands from bmpa_queue.
module bmpa_back import bmpa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  bmpa_qstat_t qstat,
  input  bmpa_cmd_t   head,
  output logic        pop,
  output logic        result_valid,
  input  logic        result_ready,
  output bmpa_out_t   result_data
);

  logic [23:0] row_base, next_index, step, new_base;
  logic        bottom_up, can_load;

  // Take a command when the result register is free, init needs no slot
  assign can_load = !result_valid || result_ready;
  assign pop      = !qstat.empty && (head.kind == CMD_INIT || can_load);
  assign new_base = bottom_up ? (row_base - step) : (row_base + step);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (pop && head.kind != CMD_INIT) begin
        result_valid <= 1'b1;
      end
    end
  end

  // Load the result and step the index
  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.kind)
        CMD_INIT: begin
          row_base   <= head.data;
          next_index <= head.data;
          step       <= head.step;
          bottom_up  <= head.bottom_up;
        end
        CMD_PIXEL: begin
          result_data.status      <= STATUS_PIXEL;
          result_data.pixel_index <= next_index;
          result_data.pixel_color <= {ALPHA_OPAQUE, head.data};
          result_data.last_pixel  <= head.last;
          if (head.row_end) begin
            row_base   <= new_base;
            next_index <= new_base;
          end else begin
            next_index <= next_index + 24'd1;
          end
        end
        CMD_ERROR: begin
          result_data.status      <= head.status;
          result_data.pixel_index <= '0;
          result_data.pixel_color <= '0;
          result_data.last_pixel  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/bmp_stream_to_argb_pixels_top.sv]
// Channel   Dir  Handshake                   Payload
// byte      in   byte_valid / byte_ready     byte_data: byte_value, start_of_file
// result    out  result_valid / result_ready result_data: status, index, color, last
//
// Takes one byte per cycle while byte_ready is high; the byte that completes a result
// pushes a command into the queue, from which it is loaded into the output register.
// Rate is set by the byte parser and the 4-entry command queue.
// Reset clears the parser to byte 0 of a header, empties the queue and the output.
// When the output stalls the queue fills, then byte_ready drops.
// Depends on bmpa_pkg, bmpa_front, bmpa_queue, bmpa_back and the assertion header.
`include "bmp_stream_to_argb_pixels_top_assert.svh"

module bmp_stream_to_argb_pixels_top import bmpa_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  bmpa_in_t  byte_data,
  output logic      result_valid,
  input  logic      result_ready,
  output bmpa_out_t result_data
);

  bmpa_qstat_t qstat;
  bmpa_cmd_t   push_cmd, head;
  logic        push, pop;
  logic        err_out, pix_out, err_clean, alpha_ok, pop_result;

  // Parse bytes into commands
  bmpa_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .qstat      (qstat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // Buffer commands
  bmpa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // Turn commands into results
  bmpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  // Checks
  assign err_out    = result_valid && result_data.status != STATUS_PIXEL;
  assign pix_out    = result_valid && result_data.status == STATUS_PIXEL;
  assign err_clean  = result_data.pixel_index == 24'd0 && result_data.pixel_color == 32'd0 &&
                      !result_data.last_pixel;
  assign alpha_ok   = result_data.pixel_color[31:24] == ALPHA_OPAQUE;
  assign pop_result = pop && head.kind != CMD_INIT;

  `BMPA_ASSERT_NOW(a_error_fields_zero, err_out, err_clean, "error result with nonzero fields")
  `BMPA_ASSERT_NOW(a_pixel_opaque, pix_out, alpha_ok, "pixel result without opaque alpha")
  `BMPA_ASSERT_NOW(a_no_push_when_full, push, !qstat.full, "command pushed into a full queue")
  `BMPA_ASSERT_NOW(a_no_pop_when_empty, pop, !qstat.empty, "command popped from an empty queue")
  `BMPA_ASSERT_NEXT(a_pop_loads_result, pop_result, result_valid, "popped result not presented")

endmodule
